// ----- rtl/core/planar_vector_rotate_core_macros.svh -----
// ---------------------------------------------------------------------------
// planar_vector_rotate_core_macros
// assertion shorthands for the planar vector rotate checker
// ---------------------------------------------------------------------------
`ifndef PLANAR_VECTOR_ROTATE_CORE_MACROS_SVH
`define PLANAR_VECTOR_ROTATE_CORE_MACROS_SVH

// checked only outside reset
`define PVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PVR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/pvr_pkg.sv -----
// ---------------------------------------------------------------------------
// pvr_pkg
// constants shared by the planar vector rotate pipeline
// ---------------------------------------------------------------------------
package pvr_pkg;

  localparam int GUARD_BITS    = 8;
  localparam int ATAN_LEN      = 24;
  localparam int PREP_STAGES   = 5;
  localparam int FINISH_STAGES = 1;

  // 1/K for the cordic gain, unsigned fraction of 2^32
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  // atan(2^-i) with a full turn equal to 2^32
  localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  function automatic int stage_count(int stages);
    return (stages > ATAN_LEN) ? ATAN_LEN : stages;
  endfunction

endpackage

// ----- rtl/core/pvr_prep.sv -----
// ---------------------------------------------------------------------------
// pvr_prep
// angle fold into the right half plane and gain pre-scaling, five stages
// ---------------------------------------------------------------------------
module pvr_prep #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16,
  parameter int IW          = 42
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [ANGLE_WIDTH-1:0]        yaw_angle,
  input  logic signed [COORD_WIDTH-1:0] x_in,
  input  logic signed [COORD_WIDTH-1:0] y_in,
  input  logic signed [COORD_WIDTH-1:0] z_in,
  output logic                          out_valid,
  output logic [31:0]                   t_out,
  output logic signed [IW-1:0]          x_out,
  output logic signed [IW-1:0]          y_out,
  output logic signed [COORD_WIDTH-1:0] z_out
);
  import pvr_pkg::*;

  localparam int MW  = COORD_WIDTH + GUARD_BITS;
  localparam int MPW = (MW > 32) ? MW : 33;
  localparam int HW  = MPW - 32;
  localparam int RW  = HW + 33;
  localparam int XW  = (RW > IW) ? RW : IW;

  // stage a: fold
  logic [31:0]          phase;
  logic [31:0]          t0;
  logic                 fold;
  logic signed [IW-1:0] lane_in [2];

  logic                 a_valid;
  logic [31:0]          a_t;
  logic signed [IW-1:0] a_v [2];
  logic signed [COORD_WIDTH-1:0] a_z;

  // stage b: magnitude
  logic                 b_valid;
  logic [31:0]          b_t;
  logic                 b_neg [2];
  logic [MPW-1:0]       b_mag [2];
  logic signed [COORD_WIDTH-1:0] b_z;

  // stage c: partial products
  logic                 c_valid;
  logic [31:0]          c_t;
  logic                 c_neg [2];
  logic [63:0]          c_lo [2];
  logic [HW+31:0]       c_hi [2];
  logic signed [COORD_WIDTH-1:0] c_z;

  // stage d: rounded sum
  logic                 d_valid;
  logic [31:0]          d_t;
  logic                 d_neg [2];
  logic [RW-1:0]        d_r [2];
  logic signed [COORD_WIDTH-1:0] d_z;

  // stage e: sign back
  logic                 e_valid;
  logic [31:0]          e_t;
  logic signed [IW-1:0] e_v [2];
  logic signed [COORD_WIDTH-1:0] e_z;

  logic [IW-1:0]        a_abs [2];
  logic [XW-1:0]        d_wide [2];

  assign phase = {yaw_angle, {(32 - ANGLE_WIDTH){1'b0}}};
  assign t0    = 32'd0 - phase;
  // second or third quarter: turn by half a turn first
  assign fold  = t0[31] ^ t0[30];

  assign lane_in[0] = {{(IW - COORD_WIDTH){x_in[COORD_WIDTH-1]}}, x_in} <<< GUARD_BITS;
  assign lane_in[1] = {{(IW - COORD_WIDTH){y_in[COORD_WIDTH-1]}}, y_in} <<< GUARD_BITS;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      a_abs[l]  = a_v[l][IW-1] ? IW'(-a_v[l]) : IW'(a_v[l]);
      d_wide[l] = XW'(d_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_t <= fold ? {~t0[31], t0[30:0]} : t0;
    a_z <= z_in;
    b_t <= a_t;
    b_z <= a_z;
    c_t <= b_t;
    c_z <= b_z;
    d_t <= c_t;
    d_z <= c_z;
    e_t <= d_t;
    e_z <= d_z;
    for (int l = 0; l < 2; l++) begin
      a_v[l]   <= fold ? -lane_in[l] : lane_in[l];
      b_neg[l] <= a_v[l][IW-1];
      b_mag[l] <= MPW'(a_abs[l][MW-1:0]);
      c_neg[l] <= b_neg[l];
      c_lo[l]  <= 64'(b_mag[l][31:0]) * 64'(GAIN_Q32);
      c_hi[l]  <= (HW + 32)'(b_mag[l][MPW-1:32]) * (HW + 32)'(GAIN_Q32);
      d_neg[l] <= c_neg[l];
      // round half up on the low partial product
      d_r[l]   <= RW'(c_hi[l]) + RW'((c_lo[l] + 64'h0000_0000_8000_0000) >> 32);
      e_v[l]   <= d_neg[l] ? -signed'(d_wide[l][IW-1:0]) : signed'(d_wide[l][IW-1:0]);
    end
  end

  assign out_valid = e_valid;
  assign t_out     = e_t;
  assign x_out     = e_v[0];
  assign y_out     = e_v[1];
  assign z_out     = e_z;

endmodule

// ----- rtl/core/pvr_cordic_stage.sv -----
// ---------------------------------------------------------------------------
// pvr_cordic_stage
// one registered micro-rotation of the cordic chain
// ---------------------------------------------------------------------------
module pvr_cordic_stage #(
  parameter int COORD_WIDTH = 32,
  parameter int IW          = 42,
  parameter int STAGE       = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [31:0]                   t_in,
  input  logic signed [IW-1:0]          x_in,
  input  logic signed [IW-1:0]          y_in,
  input  logic signed [COORD_WIDTH-1:0] z_in,
  output logic                          out_valid,
  output logic [31:0]                   t_out,
  output logic signed [IW-1:0]          x_out,
  output logic signed [IW-1:0]          y_out,
  output logic signed [COORD_WIDTH-1:0] z_out
);
  import pvr_pkg::*;

  logic signed [IW-1:0] dx;
  logic signed [IW-1:0] dy;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    z_out <= z_in;
    // residual angle negative: rotate the other way
    if (t_in[31]) begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      t_out <= t_in + ATAN_TURN[STAGE];
    end else begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      t_out <= t_in - ATAN_TURN[STAGE];
    end
  end

endmodule

// ----- rtl/core/pvr_finish.sv -----
// ---------------------------------------------------------------------------
// pvr_finish
// drop guard bits with round half up and clamp to the coordinate range
// ---------------------------------------------------------------------------
module pvr_finish #(
  parameter int COORD_WIDTH = 32,
  parameter int IW          = 42
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [IW-1:0]          x_in,
  input  logic signed [IW-1:0]          y_in,
  input  logic signed [COORD_WIDTH-1:0] z_in,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] x_out,
  output logic signed [COORD_WIDTH-1:0] y_out,
  output logic signed [COORD_WIDTH-1:0] z_out
);
  import pvr_pkg::*;

  localparam int SW  = IW - GUARD_BITS;
  localparam int RND = 1 << (GUARD_BITS - 1);
  localparam logic signed [SW-1:0] TOP =
    {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] BOT = ~TOP;

  logic signed [IW-1:0] lane_in [2];
  logic signed [IW-1:0] shifted [2];
  logic signed [SW-1:0] rounded [2];
  logic signed [COORD_WIDTH-1:0] clamped [2];

  assign lane_in[0] = x_in;
  assign lane_in[1] = y_in;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      shifted[l] = (lane_in[l] + signed'(IW'(RND))) >>> GUARD_BITS;
      rounded[l] = shifted[l][SW-1:0];
      if (rounded[l] > TOP) begin
        clamped[l] = TOP[COORD_WIDTH-1:0];
      end else if (rounded[l] < BOT) begin
        clamped[l] = BOT[COORD_WIDTH-1:0];
      end else begin
        clamped[l] = rounded[l][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_out <= clamped[0];
    y_out <= clamped[1];
    z_out <= z_in;
  end

endmodule

// ----- rtl/core/planar_vector_rotate_core.sv -----
// ---------------------------------------------------------------------------
// planar_vector_rotate_core
// rotates (x, y) by minus the yaw angle with a pipelined cordic, z passes
// ---------------------------------------------------------------------------
// A new item may be started on every clock cycle; busy is high only while
// rst is asserted. Each item comes out on done after passing through
// five stages of angle folding and gain scaling, one registered stage per
// cordic micro-rotation, and one stage of rounding and saturation. The
// result ports hold a value for one cycle only, so the receiver must
// capture every cycle in which done is high.
module planar_vector_rotate_core #(
  parameter int COORD_WIDTH   = 32,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ANGLE_WIDTH-1:0]        yaw_angle,
  input  logic signed [COORD_WIDTH-1:0] x_in,
  input  logic signed [COORD_WIDTH-1:0] y_in,
  input  logic signed [COORD_WIDTH-1:0] z_in,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] x_out,
  output logic signed [COORD_WIDTH-1:0] y_out,
  output logic signed [COORD_WIDTH-1:0] z_out
);
  import pvr_pkg::*;

  localparam int N  = stage_count(CORDIC_STAGES);
  // guard bits plus room for the cordic growth
  localparam int IW = COORD_WIDTH + GUARD_BITS + 2;

  logic                          cv [N+1];
  logic [31:0]                   ct [N+1];
  logic signed [IW-1:0]          cx [N+1];
  logic signed [IW-1:0]          cy [N+1];
  logic signed [COORD_WIDTH-1:0] cz [N+1];

  assign busy = rst;

  pvr_prep #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .IW         (IW)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .yaw_angle(yaw_angle),
    .x_in     (x_in),
    .y_in     (y_in),
    .z_in     (z_in),
    .out_valid(cv[0]),
    .t_out    (ct[0]),
    .x_out    (cx[0]),
    .y_out    (cy[0]),
    .z_out    (cz[0])
  );

  for (genvar s = 0; s < N; s++) begin : g_stage
    pvr_cordic_stage #(
      .COORD_WIDTH(COORD_WIDTH),
      .IW         (IW),
      .STAGE      (s)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[s]),
      .t_in     (ct[s]),
      .x_in     (cx[s]),
      .y_in     (cy[s]),
      .z_in     (cz[s]),
      .out_valid(cv[s+1]),
      .t_out    (ct[s+1]),
      .x_out    (cx[s+1]),
      .y_out    (cy[s+1]),
      .z_out    (cz[s+1])
    );
  end

  pvr_finish #(
    .COORD_WIDTH(COORD_WIDTH),
    .IW         (IW)
  ) u_finish (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cv[N]),
    .x_in     (cx[N]),
    .y_in     (cy[N]),
    .z_in     (cz[N]),
    .out_valid(done),
    .x_out    (x_out),
    .y_out    (y_out),
    .z_out    (z_out)
  );

endmodule

// ----- rtl/core/pvr_checker.sv -----
// ---------------------------------------------------------------------------
// pvr_checker
// port-level timing checks for planar_vector_rotate_core
// ---------------------------------------------------------------------------
`include "planar_vector_rotate_core_macros.svh"

module pvr_checker #(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] z_in,
  input logic                          done,
  input logic signed [COORD_WIDTH-1:0] z_out
);
  import pvr_pkg::*;

  localparam int LATENCY = PREP_STAGES + stage_count(CORDIC_STAGES) + FINISH_STAGES;

  // every item taken comes out after the fixed latency
  `PVR_ASSERT(a_item_out, (start && !busy) |-> ##LATENCY done, "item lost in pipeline")

  // no result without an item taken at the matching cycle
  `PVR_ASSERT(a_no_extra, done |-> $past(start && !busy, LATENCY), "result without item")

  // z rides along unchanged with its item
  `PVR_ASSERT(a_z_pass, done |-> (z_out == $past(z_in, LATENCY)), "z out of step")

  // reset flushes the pipeline
  `PVR_ASSERT_ALWAYS(a_rst_flush, rst |=> !done, "result during reset")

endmodule

bind planar_vector_rotate_core pvr_checker #(
  .COORD_WIDTH  (COORD_WIDTH),
  .CORDIC_STAGES(CORDIC_STAGES)
) u_pvr_checker (.*);

// ----- tb/sv/planar_vector_rotate_core_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// planar_vector_rotate_core_tb
// drives yaw/position items into the rotate core and checks every result
// against a bit-exact cordic predictor kept in the testbench; directed
// angle and saturation items come first, then a long random stream
// ---------------------------------------------------------------------------
module planar_vector_rotate_core_tb;

  localparam int COORD_W     = 32;
  localparam int ANGLE_W     = 16;
  localparam int STAGES      = 16;
  localparam int GUARD       = 8;
  localparam int RUN_STAGES  = (STAGES > 24) ? 24 : STAGES;
  localparam int LATENCY     = 6 + RUN_STAGES;
  localparam int STALL_LIMIT = 400;
  localparam int RANDOM_ITEMS = 600;

  localparam logic [63:0] INV_GAIN = 64'h0000_0000_9B74_EDA8;
  localparam logic signed [63:0] COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
  localparam logic signed [63:0] COORD_MIN = -COORD_MAX - 64'sd1;
  localparam logic signed [COORD_W-1:0] C_MAX = COORD_MAX[COORD_W-1:0];
  localparam logic signed [COORD_W-1:0] C_MIN = COORD_MIN[COORD_W-1:0];
  localparam logic signed [COORD_W-1:0] C_ONE = 1 <<< 16;

  // arctan(2^-i), full turn = 2^32
  localparam logic [31:0] MICRO_ANGLE [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [ANGLE_W-1:0] yaw_angle = '0;
  logic signed [COORD_W-1:0] x_in = '0;
  logic signed [COORD_W-1:0] y_in = '0;
  logic signed [COORD_W-1:0] z_in = '0;
  logic busy;
  logic done;
  logic signed [COORD_W-1:0] x_out;
  logic signed [COORD_W-1:0] y_out;
  logic signed [COORD_W-1:0] z_out;

  pose_t expected_poses[$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  int burst_left = 0;

  planar_vector_rotate_core #(
    .COORD_WIDTH(COORD_W),
    .ANGLE_WIDTH(ANGLE_W),
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .yaw_angle(yaw_angle),
    .x_in(x_in),
    .y_in(y_in),
    .z_in(z_in),
    .done(done),
    .x_out(x_out),
    .y_out(y_out),
    .z_out(z_out)
  );

  always #2 clk = ~clk;

  // multiply by 1/K, magnitude rounded half away from zero
  function automatic logic signed [63:0] scale_by_gain(logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] r;
    mag = v[63] ? -v : v;
    hi = mag >> 32;
    lo = {32'd0, mag[31:0]};
    r = hi * INV_GAIN + ((lo * INV_GAIN + 64'h8000_0000) >> 32);
    return v[63] ? -r : r;
  endfunction

  function automatic logic signed [COORD_W-1:0] round_clamp(logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < COORD_MIN) r = COORD_MIN;
    return r[COORD_W-1:0];
  endfunction

  function automatic pose_t rotate_by_minus_yaw(logic [ANGLE_W-1:0] ang,
                                                logic signed [COORD_W-1:0] xv,
                                                logic signed [COORD_W-1:0] yv,
                                                logic signed [COORD_W-1:0] zv);
    logic [31:0] turn;
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    pose_t res;
    turn = 32'd0 - (32'(ang) << (32 - ANGLE_W));
    px = xv;
    py = yv;
    // fold the left half plane onto the right one
    if (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) begin
      px = -px;
      py = -py;
      turn = turn + 32'h8000_0000;
    end
    px = scale_by_gain(px <<< GUARD);
    py = scale_by_gain(py <<< GUARD);
    for (int i = 0; i < RUN_STAGES; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (turn[31]) begin
        px = px + dx;
        py = py - dy;
        turn = turn + MICRO_ANGLE[i];
      end else begin
        px = px - dx;
        py = py + dy;
        turn = turn - MICRO_ANGLE[i];
      end
    end
    res.x = round_clamp(px);
    res.y = round_clamp(py);
    res.z = zv;
    return res;
  endfunction

  // result checker, the receiver never stalls
  always @(posedge clk) begin
    pose_t want;
    if (!rst && done) begin
      if (expected_poses.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h %h %h",
                 $time, x_out, y_out, z_out);
        mismatch_count++;
      end else begin
        want = expected_poses.pop_front();
        if (x_out !== want.x) begin
          $display("%0t x_out: expected %h actual %h", $time, want.x, x_out);
          mismatch_count++;
        end
        if (y_out !== want.y) begin
          $display("%0t y_out: expected %h actual %h", $time, want.y, y_out);
          mismatch_count++;
        end
        if (z_out !== want.z) begin
          $display("%0t z_out: expected %h actual %h", $time, want.z, z_out);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // start stays high across back-to-back items
  task automatic send_item(input logic [ANGLE_W-1:0] ang,
                           input logic signed [COORD_W-1:0] xv,
                           input logic signed [COORD_W-1:0] yv,
                           input logic signed [COORD_W-1:0] zv,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    yaw_angle <= ang;
    x_in <= xv;
    y_in <= yv;
    z_in <= zv;
    do @(posedge clk); while (busy);
    expected_poses.push_back(rotate_by_minus_yaw(ang, xv, yv, zv));
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_poses.size() != 0);
  endtask

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // about a fifth of the angles sit within two units of a quadrant edge
  function automatic logic [ANGLE_W-1:0] draw_angle();
    logic [ANGLE_W-1:0] a;
    if ($urandom_range(0, 4) == 0) begin
      a = ANGLE_W'($urandom_range(0, 3)) << (ANGLE_W - 2);
      a = a + ANGLE_W'($urandom_range(0, 4)) - ANGLE_W'(2);
    end else begin
      a = ANGLE_W'($urandom);
    end
    return a;
  endfunction

  function automatic logic signed [COORD_W-1:0] draw_coord();
    logic signed [COORD_W-1:0] c;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      c = $urandom;
    end else if (sel == 4) begin
      case ($urandom_range(0, 4))
        0: c = C_MIN;
        1: c = C_MAX;
        2: c = '0;
        3: c = -1;
        default: c = 1;
      endcase
    end else begin
      c = $signed($urandom) >>> $urandom_range(0, 30);
    end
    return c;
  endfunction

  task automatic test_cardinal_angles();
    send_item(16'h0000, C_ONE, 0, 0, 0);
    send_item(16'h4000, C_ONE, 0, C_MAX, 0);
    send_item(16'h8000, C_ONE, C_ONE, C_MIN, 0);
    send_item(16'hC000, 0, C_ONE, 0, 1);
    send_item(16'hFFFF, C_ONE, -C_ONE, -1, 0);
    send_item(16'h3FFF, C_ONE, 0, 1, 2);
    send_item(16'h4001, -C_ONE, C_ONE, 0, 0);
    send_item(16'hBFFF, C_ONE, 0, 0, 0);
    send_item(16'hC001, 0, -C_ONE, 0, 3);
    send_item(16'h2000, C_ONE, C_ONE, 0, 0);
    send_item(16'h1555, 32'sd12345, -32'sd67890, 0, 0);
    send_item(16'h0001, 1, -1, 0, 0);
  endtask

  task automatic test_saturation_extremes();
    // one coordinate grows by sqrt(2) at 45 degrees and clips
    send_item(16'h2000, C_MIN, C_MIN, C_MIN, 0);
    send_item(16'hE000, C_MAX, C_MAX, C_MAX, 0);
    send_item(16'h6000, C_MAX, C_MIN, 0, 1);
    send_item(16'hA000, C_MIN, C_MAX, 0, 0);
    // most negative coordinate negated at full width, must clip not wrap
    send_item(16'h8000, C_MIN, C_MIN, 0, 0);
    send_item(16'h0000, C_MIN, C_MAX, C_MAX, 0);
    send_item(16'h4000, C_MIN, 0, 0, 2);
    send_item(16'h0000, 0, 0, 0, 0);
    hold_until_drained();
  endtask

  task automatic test_back_to_back();
    for (int i = 0; i < 40; i++)
      send_item(draw_angle(), draw_coord(), draw_coord(), draw_coord(), 0);
    hold_until_drained();
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_item(draw_angle(), draw_coord(), draw_coord(), draw_coord(), draw_gap());
      if (i % 200 == 199) hold_until_drained();
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_cardinal_angles();
    test_saturation_extremes();
    test_back_to_back();
    test_random_stream();
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
